// ===== rtl/core/dpi_pkg.sv =====
package dpi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int STEP_FRAC = 16;
  localparam int Q30       = 30;
  localparam int LOG_BITS  = 24;
  localparam int DUR_BITS  = 16;
  localparam int DAMP_BITS = 17;
  localparam int MUL_W     = WORD_BITS + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = PROD_W;
  localparam int NL_W      = 29;
  localparam int CNT_W     = 5;

  localparam logic [2:0] OP_ADD_FORCE  = 3'd0;
  localparam logic [2:0] OP_INTEGRATE  = 3'd1;
  localparam logic [2:0] OP_LOAD_POS   = 3'd2;
  localparam logic [2:0] OP_LOAD_VEL   = 3'd3;
  localparam logic [2:0] OP_CLR_FORCE  = 3'd4;

  localparam logic [2:0] CFG_INV_MASS  = 3'd0;
  localparam logic [2:0] CFG_DAMPING   = 3'd1;
  localparam logic [2:0] CFG_ACCEL_X   = 3'd2;
  localparam logic [2:0] CFG_ACCEL_Z   = 3'd4;

  localparam logic signed [SUM_W-1:0] WORD_MAX =
    {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] WORD_MIN = ~WORD_MAX;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [WORD_BITS-1:0] value_x;
    logic signed [WORD_BITS-1:0] value_y;
    logic signed [WORD_BITS-1:0] value_z;
    logic [DUR_BITS-1:0]         duration;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
    logic signed [WORD_BITS-1:0] vel_x;
    logic signed [WORD_BITS-1:0] vel_y;
    logic signed [WORD_BITS-1:0] vel_z;
    logic                        saturated;
  } out_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_NL_MUL, S_NL_ACC, S_EXP, S_FAC, S_AX_MUL, S_AX_ACC, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ST_POS, ST_ACC, ST_VEL, ST_DAMP
  } step_t;

  typedef logic [LOG_BITS:0][Q30:0] exp_tbl_t;

  // Entry i is 2^(-2^-i) in Q1.30, built by a floor square root chain from one half.
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    t      = 64'd1 << (Q30 - 1);
    tbl[0] = t[Q30:0];
    for (int i = 1; i <= LOG_BITS; i++) begin
      n     = t << Q30;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 64'd0) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      t      = res;
      tbl[i] = t[Q30:0];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  function automatic logic signed [SUM_W-1:0] sext_word(logic signed [WORD_BITS-1:0] v);
    return {{(SUM_W-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  // Returns {clipped flag, clipped word}.
  function automatic logic [WORD_BITS:0] clip_word(logic signed [SUM_W-1:0] v);
    logic [WORD_BITS:0] r;
    if (v > WORD_MAX) begin
      r = {1'b1, WORD_MAX[WORD_BITS-1:0]};
    end else if (v < WORD_MIN) begin
      r = {1'b1, WORD_MIN[WORD_BITS-1:0]};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/damped_particle_integrator.sv =====
// Channel   Direction  Handshake                  Payload
// in_       input      in_valid / in_ready        dpi_pkg::in_req_t
// out_      output     out_valid / out_ready      dpi_pkg::out_req_t
// cfg_      input      cfg_we (no wait)           cfg_index, cfg_wdata
//
// Add force, load position, load velocity and clear forces update the state at
// acceptance; the emit state then hands the result to the output register.
// Integrate runs on the single shared 33x33 multiplier: 24 log2 squaring
// steps, one scaling multiply, 24 exp2 steps and four multiplies per axis,
// each a multiply state and an accumulate state. With damping of zero, one or
// above, or a zero duration, the log2/exp2 phase is skipped. Reset is synchronous
// and active low. A pending result waits in the output register without blocking
// the next request; the block is busy during integrate.
module damped_particle_integrator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  dpi_pkg::in_req_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dpi_pkg::out_req_t        out_data,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [dpi_pkg::WORD_BITS-1:0] cfg_wdata
);

  localparam int W  = dpi_pkg::WORD_BITS;
  localparam int CW = dpi_pkg::CNT_W;

  // Sequencer state and the shared multiplier's product register.
  dpi_pkg::state_t state_r, state_nxt;
  dpi_pkg::step_t  step_r, step_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic signed [dpi_pkg::PROD_W-1:0] prod_r;

  // Particle state.
  logic signed [W-1:0] pos_r [3];
  logic signed [W-1:0] vel_r [3];
  logic signed [W-1:0] frc_r [3];
  logic signed [W-1:0] pos_nxt [3];
  logic signed [W-1:0] vel_nxt [3];
  logic signed [W-1:0] frc_nxt [3];

  // Configuration registers.
  logic [W-1:0]                  imass_r;
  logic [dpi_pkg::DAMP_BITS-1:0] damp_r;
  logic signed [W-1:0]           accel_r [3];

  // Working registers of one integrate request.
  logic [dpi_pkg::DUR_BITS-1:0] dur_r, dur_nxt;
  logic                         flag_r, flag_nxt;
  logic [3:0]                   lead_r, lead_nxt;
  logic [W-1:0]                 m_r, m_nxt;
  logic [dpi_pkg::LOG_BITS-1:0] frac_r, frac_nxt;
  logic [dpi_pkg::NL_W-1:0]     e_r, e_nxt;
  logic [dpi_pkg::Q30:0]        r_r, r_nxt;
  logic [dpi_pkg::Q30:0]        fac_r, fac_nxt;
  logic signed [W-1:0]          acc_r, acc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  dpi_pkg::out_req_t    out_data_r, out_data_nxt;

  // Shared multiplier.
  logic signed [dpi_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [dpi_pkg::PROD_W-1:0] mul_p;

  logic accept;
  logic emit;
  logic special_damp;
  logic [3:0] lead;

  localparam logic [dpi_pkg::Q30:0] ONE_Q30 = {1'b1, {dpi_pkg::Q30{1'b0}}};

  assign in_ready  = (state_r == dpi_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit      = (state_r == dpi_pkg::S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mul_p     = mul_a * mul_b;

  // Damping of zero, one or above, or a zero step needs no log2/exp2 pass.
  assign special_damp = damp_r[dpi_pkg::DAMP_BITS-1] || (damp_r == '0) ||
                        (in_data.duration == '0);

  // Position of the leading one of the damping mantissa.
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (damp_r[i]) lead = 4'(i);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpi_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.op == dpi_pkg::OP_INTEGRATE) begin
            state_nxt = special_damp ? dpi_pkg::S_AX_MUL : dpi_pkg::S_LOG;
          end else begin
            state_nxt = dpi_pkg::S_EMIT;
          end
        end
      end
      dpi_pkg::S_LOG: begin
        if (cnt_r == CW'(dpi_pkg::LOG_BITS - 1)) state_nxt = dpi_pkg::S_NL_MUL;
      end
      dpi_pkg::S_NL_MUL: state_nxt = dpi_pkg::S_NL_ACC;
      dpi_pkg::S_NL_ACC: state_nxt = dpi_pkg::S_EXP;
      dpi_pkg::S_EXP: begin
        if (cnt_r == CW'(dpi_pkg::LOG_BITS - 1)) state_nxt = dpi_pkg::S_FAC;
      end
      dpi_pkg::S_FAC:    state_nxt = dpi_pkg::S_AX_MUL;
      dpi_pkg::S_AX_MUL: state_nxt = dpi_pkg::S_AX_ACC;
      dpi_pkg::S_AX_ACC: begin
        if (step_r == dpi_pkg::ST_DAMP && axis_r == 2'd2) begin
          state_nxt = dpi_pkg::S_EMIT;
        end else begin
          state_nxt = dpi_pkg::S_AX_MUL;
        end
      end
      dpi_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = dpi_pkg::S_IDLE;
      end
      default: state_nxt = dpi_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic signed [dpi_pkg::SUM_W-1:0]  sum;
    logic signed [dpi_pkg::PROD_W-1:0] sh;
    logic [W:0]                        cl;
    logic [W-1:0]                      sq;
    logic [dpi_pkg::NL_W-1:0]          nl;
    logic [CW-1:0]                     k;
    logic signed [W-1:0]               vals [3];

    step_nxt     = step_r;
    axis_nxt     = axis_r;
    cnt_nxt      = cnt_r;
    dur_nxt      = dur_r;
    flag_nxt     = flag_r;
    lead_nxt     = lead_r;
    m_nxt        = m_r;
    frac_nxt     = frac_r;
    e_nxt        = e_r;
    r_nxt        = r_r;
    fac_nxt      = fac_r;
    acc_nxt      = acc_r;
    mul_a        = '0;
    mul_b        = '0;
    sum          = '0;
    sh           = '0;
    cl           = '0;
    sq           = '0;
    nl           = '0;
    k            = '0;
    vals[0]      = in_data.value_x;
    vals[1]      = in_data.value_y;
    vals[2]      = in_data.value_z;
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      vel_nxt[i] = vel_r[i];
      frc_nxt[i] = frc_r[i];
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      dpi_pkg::S_IDLE: begin
        if (accept) begin
          flag_nxt = 1'b0;
          dur_nxt  = in_data.duration;
          cnt_nxt  = '0;
          axis_nxt = 2'd0;
          step_nxt = dpi_pkg::ST_POS;
          lead_nxt = lead;
          frac_nxt = '0;
          m_nxt    = {16'b0, damp_r[15:0]} << (5'd30 - {1'b0, lead});
          // A zero step keeps the velocity even when damping is zero.
          if (damp_r == '0 && in_data.duration != '0) begin
            fac_nxt = '0;
          end else begin
            fac_nxt = ONE_Q30;
          end
          case (in_data.op)
            dpi_pkg::OP_ADD_FORCE: begin
              for (int i = 0; i < 3; i++) begin
                cl = dpi_pkg::clip_word(dpi_pkg::sext_word(frc_r[i]) +
                                        dpi_pkg::sext_word(vals[i]));
                frc_nxt[i] = cl[W-1:0];
                if (cl[W]) flag_nxt = 1'b1;
              end
            end
            dpi_pkg::OP_LOAD_POS: begin
              for (int i = 0; i < 3; i++) pos_nxt[i] = vals[i];
            end
            dpi_pkg::OP_LOAD_VEL: begin
              for (int i = 0; i < 3; i++) vel_nxt[i] = vals[i];
            end
            dpi_pkg::OP_CLR_FORCE: begin
              for (int i = 0; i < 3; i++) frc_nxt[i] = '0;
            end
            default: ;
          endcase
        end
      end

      // One squaring of the Q1.30 mantissa per cycle yields one log2 fraction bit.
      dpi_pkg::S_LOG: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
        sq    = mul_p[dpi_pkg::Q30+W-1:dpi_pkg::Q30];
        if (sq[W-1]) begin
          m_nxt    = sq >> 1;
          frac_nxt = {frac_r[dpi_pkg::LOG_BITS-2:0], 1'b1};
        end else begin
          m_nxt    = sq;
          frac_nxt = {frac_r[dpi_pkg::LOG_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
      end

      // Magnitude of log2 times the step gives the exponent E.
      dpi_pkg::S_NL_MUL: begin
        nl    = {5'd16 - {1'b0, lead_r}, {dpi_pkg::LOG_BITS{1'b0}}} -
                {5'b0, frac_r};
        mul_a = {4'b0, nl};
        mul_b = {17'b0, dur_r};
      end
      dpi_pkg::S_NL_ACC: begin
        e_nxt   = prod_r[dpi_pkg::NL_W+15:16];
        r_nxt   = ONE_Q30;
        cnt_nxt = '0;
      end

      // One table factor per fraction bit of E, most significant first.
      dpi_pkg::S_EXP: begin
        mul_a = {2'b0, r_r};
        mul_b = {2'b0, dpi_pkg::EXP_TBL[cnt_r + CW'(1)]};
        if (e_r[CW'(dpi_pkg::LOG_BITS - 1) - cnt_r]) begin
          r_nxt = mul_p[2*dpi_pkg::Q30:dpi_pkg::Q30];
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      dpi_pkg::S_FAC: begin
        k = e_r[dpi_pkg::NL_W-1:dpi_pkg::LOG_BITS];
        if (k == 5'd31) begin
          fac_nxt = '0;
        end else begin
          fac_nxt = r_r >> k;
        end
      end

      dpi_pkg::S_AX_MUL: begin
        case (step_r)
          dpi_pkg::ST_POS: begin
            mul_a = {vel_r[axis_r][W-1], vel_r[axis_r]};
            mul_b = {17'b0, dur_r};
          end
          dpi_pkg::ST_ACC: begin
            mul_a = {frc_r[axis_r][W-1], frc_r[axis_r]};
            mul_b = {1'b0, imass_r};
          end
          dpi_pkg::ST_VEL: begin
            mul_a = {acc_r[W-1], acc_r};
            mul_b = {17'b0, dur_r};
          end
          dpi_pkg::ST_DAMP: begin
            mul_a = {vel_r[axis_r][W-1], vel_r[axis_r]};
            mul_b = {2'b0, fac_r};
          end
          default: ;
        endcase
      end

      dpi_pkg::S_AX_ACC: begin
        case (step_r)
          dpi_pkg::ST_POS: begin
            sum = dpi_pkg::sext_word(pos_r[axis_r]) + (prod_r >>> dpi_pkg::STEP_FRAC);
            cl  = dpi_pkg::clip_word(sum);
            pos_nxt[axis_r] = cl[W-1:0];
            if (cl[W]) flag_nxt = 1'b1;
            step_nxt = dpi_pkg::ST_ACC;
          end
          dpi_pkg::ST_ACC: begin
            sum = dpi_pkg::sext_word(accel_r[axis_r]) + (prod_r >>> dpi_pkg::FRAC_BITS);
            cl  = dpi_pkg::clip_word(sum);
            acc_nxt = cl[W-1:0];
            if (cl[W]) flag_nxt = 1'b1;
            step_nxt = dpi_pkg::ST_VEL;
          end
          dpi_pkg::ST_VEL: begin
            sum = dpi_pkg::sext_word(vel_r[axis_r]) + (prod_r >>> dpi_pkg::STEP_FRAC);
            cl  = dpi_pkg::clip_word(sum);
            vel_nxt[axis_r] = cl[W-1:0];
            if (cl[W]) flag_nxt = 1'b1;
            step_nxt = dpi_pkg::ST_DAMP;
          end
          dpi_pkg::ST_DAMP: begin
            sh = prod_r >>> dpi_pkg::Q30;
            vel_nxt[axis_r] = sh[W-1:0];
            frc_nxt[axis_r] = '0;
            step_nxt = dpi_pkg::ST_POS;
            axis_nxt = axis_r + 2'd1;
          end
          default: ;
        endcase
      end

      dpi_pkg::S_EMIT: begin
        if (emit) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.pos_x     = pos_r[0];
          out_data_nxt.pos_y     = pos_r[1];
          out_data_nxt.pos_z     = pos_r[2];
          out_data_nxt.vel_x     = vel_r[0];
          out_data_nxt.vel_y     = vel_r[1];
          out_data_nxt.vel_z     = vel_r[2];
          out_data_nxt.saturated = flag_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpi_pkg::S_IDLE;
      step_r      <= dpi_pkg::ST_POS;
      axis_r      <= 2'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
      imass_r     <= '0;
      damp_r      <= {1'b1, 16'b0};
      for (int i = 0; i < 3; i++) begin
        pos_r[i]   <= '0;
        vel_r[i]   <= '0;
        frc_r[i]   <= '0;
        accel_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      flag_r      <= flag_nxt;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_nxt[i];
        vel_r[i] <= vel_nxt[i];
        frc_r[i] <= frc_nxt[i];
      end
      // Writes to indexes beyond the register list are dropped.
      if (cfg_we) begin
        case (cfg_index)
          dpi_pkg::CFG_INV_MASS: imass_r <= cfg_wdata;
          dpi_pkg::CFG_DAMPING:  damp_r  <= cfg_wdata[dpi_pkg::DAMP_BITS-1:0];
          default: begin
            if (cfg_index >= dpi_pkg::CFG_ACCEL_X && cfg_index <= dpi_pkg::CFG_ACCEL_Z) begin
              accel_r[2'(cfg_index - dpi_pkg::CFG_ACCEL_X)] <= cfg_wdata;
            end
          end
        endcase
      end
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    prod_r     <= mul_p;
    dur_r      <= dur_nxt;
    lead_r     <= lead_nxt;
    m_r        <= m_nxt;
    frac_r     <= frac_nxt;
    e_r        <= e_nxt;
    r_r        <= r_nxt;
    fac_r      <= fac_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
